>>> src/bspe_pkg.sv
// ----------------------------------------------------------------------------
// B-spline curve point evaluator: shared package
// Sizes, register indexes, sequencer states, the request and response
// structs between the top level and the core, and the knot vector function.
// ----------------------------------------------------------------------------
package bspe_pkg;

    // Table sizes
    localparam int MAX_POINTS = 16;
    localparam int MAX_ORDER  = 8;
    localparam int KNOT_LEN   = MAX_POINTS + MAX_ORDER + 1;
    localparam int KIDX_W     = $clog2(KNOT_LEN);
    localparam int KSUM_W     = KIDX_W + 1;
    localparam int PT_AW      = $clog2(MAX_POINTS);

    // Fixed-point formats
    localparam int FRAC_V = 17;               // v in units of 2^-17
    localparam int W_W    = 17;               // Q1.16 weight, up to 1.0
    localparam int VV_W   = 22;               // sample * span, below 2^21
    localparam int KV_W   = 5;                // knot value, 0 to 16
    localparam int SUM_W  = VV_W + 1;         // sum of two blend terms
    localparam int ACC_W  = 38;               // point * weight accumulator
    localparam int MA_W   = VV_W + 1;         // multiplier operand a
    localparam int MB_W   = W_W + 1;          // multiplier operand b
    localparam int MP_W   = MA_W + MB_W;      // multiplier product
    localparam int DIVQ_W = VV_W;             // divider quotient bits
    localparam int DIVD_W = KV_W;             // divider divisor bits

    localparam logic [W_W-1:0] W_ONE = 17'h1_0000;

    // Configuration register indexes
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_SPLINE_ORDER = 1'b0;
    localparam logic [CFG_AW-1:0] REG_LAST_POINT   = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VMUL,
        ST_VSET,
        ST_INIT,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_TMUL,
        ST_TDIV,
        ST_TWAIT,
        ST_WR,
        ST_ARD,
        ST_AMX,
        ST_AAX,
        ST_AAY,
        ST_RND,
        ST_OUT
    } bspe_state_t;

    // Request from the top level to the core
    typedef struct packed {
        logic               wr;
        logic [3:0]         wr_index;
        logic signed [15:0] wr_x;
        logic signed [15:0] wr_y;
        logic               start;
        logic signed [17:0] sample;
        logic [3:0]         order;
        logic [3:0]         last_idx;
    } bspe_req_t;

    // Response from the core to the top level
    typedef struct packed {
        logic               idle;
        logic               done;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               in_range;
    } bspe_rsp_t;

    // Open-uniform integer knot vector: order zeros, then 1, 2, ...,
    // then a flat top at the span count m.
    function automatic logic [KV_W-1:0] knot_val(
        input logic [KSUM_W-1:0] i,
        input logic [3:0]        ord,
        input logic [3:0]        n,
        input logic [KV_W-1:0]   m
    );
        logic [KSUM_W-1:0] d;
        d = i - KSUM_W'(ord) + KSUM_W'(1);
        if (i < KSUM_W'(ord)) begin
            return '0;
        end else if (i <= KSUM_W'(n)) begin
            return d[KV_W-1:0];
        end else begin
            return m;
        end
    endfunction

endpackage

>>> src/bspe_div.sv
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Divides an unsigned dividend by a small unsigned divisor, one quotient
// bit per cycle, and pulses done when the quotient is ready.
// ----------------------------------------------------------------------------
module bspe_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bspe_pkg::DIVQ_W-1:0]   dividend,
    input  logic [bspe_pkg::DIVD_W-1:0]   divisor,
    output logic                          done,
    output logic [bspe_pkg::DIVQ_W-1:0]   quotient
);
    import bspe_pkg::*;

    localparam int CNT_W = $clog2(DIVQ_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVQ_W-1:0] q_reg;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] dv_reg;
    logic [DIVD_W:0]   trial;
    logic              fits;

    // One restoring step: bring down the next dividend bit.
    assign trial = {rem_reg, q_reg[DIVQ_W-1]};
    assign fits  = trial >= {1'b0, dv_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(DIVQ_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            q_reg   <= dividend;
            rem_reg <= '0;
            dv_reg  <= divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            q_reg   <= {q_reg[DIVQ_W-2:0], fits};
            rem_reg <= fits ? DIVD_W'(trial - {1'b0, dv_reg}) : trial[DIVD_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> src/bspe_core.sv
// ----------------------------------------------------------------------------
// B-spline evaluation core
// Control point tables, blend weight memory and a sequencer that runs the
// Cox-de Boor recursion and the weighted sum through one shared multiplier
// and one shared divider.
// ----------------------------------------------------------------------------
module bspe_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bspe_pkg::bspe_req_t   req,
    input  logic                  out_free,
    output bspe_pkg::bspe_rsp_t   rsp
);
    import bspe_pkg::*;

    bspe_state_t state_reg, state_next;

    // Tables and weight memory
    logic signed [15:0] tx_mem [MAX_POINTS];
    logic signed [15:0] ty_mem [MAX_POINTS];
    logic signed [15:0] tx_rd_reg, ty_rd_reg;
    logic [W_W-1:0]     w_mem [KNOT_LEN];
    logic [W_W-1:0]     w_rd_reg;
    logic               w_we;
    logic [W_W-1:0]     w_wdata;
    logic [KIDX_W-1:0]  w_raddr;

    // Sequencer and datapath registers
    logic signed [17:0]     s_reg;
    logic [VV_W-1:0]        vv_reg;
    logic [KIDX_W-1:0]      idx_reg;
    logic [3:0]             t_reg;
    logic                   term_reg;
    logic [W_W-1:0]         wa_reg, wb_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [KV_W-1:0]        dsel_reg;
    logic signed [MP_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg;
    logic signed [15:0]     last_x_reg, last_y_reg;
    logic                   ok_reg;

    // Combinational helpers
    logic [3:0]             ord, n;
    logic [KV_W-1:0]        m;
    logic                   ok;
    logic [KSUM_W-1:0]      lim;
    logic                   init_end, lvl_end, acc_end;
    logic [KSUM_W-1:0]      kl_i, kh_i;
    logic [KV_W-1:0]        kl_v, kh_v, d;
    logic signed [MA_W-1:0] vv_s, kl_s, kh_s, diff;
    logic                   init_hit;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic                   skip;
    logic [39:0]            rnd_num;
    logic                   div_start, div_done;
    logic [DIVQ_W-1:0]      div_q;

    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] b;
        b = (a + 38'sd32768) >>> 16;
        if (b > 38'sd32767) begin
            return 16'sh7fff;
        end else if (b < -38'sd32768) begin
            return -16'sh8000;
        end else begin
            return b[15:0];
        end
    endfunction

    assign ord = req.order;
    assign n   = req.last_idx;
    assign m   = {1'b0, n} + 5'd2 - {1'b0, ord};

    // Evaluation is possible only for a positive sample and a usable setup.
    assign ok = (req.sample > 18'sd0) && (ord != 4'd0) && (32'(ord) <= MAX_ORDER)
                && ({1'b0, n} + 5'd2 > {1'b0, ord}) && (32'(n) < MAX_POINTS);

    // Loop bounds
    assign lim      = KSUM_W'(n) + KSUM_W'(ord);
    assign init_end = {1'b0, idx_reg} == lim - KSUM_W'(1);
    assign lvl_end  = {1'b0, idx_reg} == lim - KSUM_W'(t_reg);
    assign acc_end  = idx_reg == KIDX_W'(n);

    // Knots of the current term: the first term uses u_k and u_(k+t-1),
    // the second u_(k+1) and u_(k+t).
    assign kl_i = KSUM_W'(idx_reg) + KSUM_W'(term_reg);
    assign kh_i = KSUM_W'(idx_reg) + KSUM_W'(t_reg) - KSUM_W'(1) + KSUM_W'(term_reg);
    assign kl_v = knot_val(kl_i, ord, n, m);
    assign kh_v = knot_val(kh_i, ord, n, m);
    assign d    = kh_v - kl_v;

    assign vv_s = $signed({1'b0, vv_reg});
    assign kl_s = $signed({1'b0, kl_v, 17'b0});
    assign kh_s = $signed({1'b0, kh_v, 17'b0});
    assign diff = term_reg ? (kh_s - vv_s) : (vv_s - kl_s);

    // First-level weight: one where v lies in the knot span.
    assign init_hit = ({kl_v, 17'b0} <= vv_reg) && (vv_reg < {kh_v, 17'b0});

    // A zero span or a non-positive numerator gives a zero term.
    assign skip    = (dsel_reg == '0) || (prod_reg <= 41'sd0);
    assign rnd_num = prod_reg[39:0] + {19'b0, dsel_reg, 16'b0};

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (req.start) state_next = ok ? ST_VMUL : ST_OUT;
            ST_VMUL:  state_next = ST_VSET;
            ST_VSET:  state_next = ST_INIT;
            ST_INIT: begin
                if (init_end) state_next = (ord == 4'd1) ? ST_ARD : ST_RD0;
            end
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_RD2;
            ST_RD2:   state_next = ST_TMUL;
            ST_TMUL:  state_next = ST_TDIV;
            ST_TDIV: begin
                if (skip) state_next = term_reg ? ST_WR : ST_TMUL;
                else      state_next = ST_TWAIT;
            end
            ST_TWAIT: if (div_done) state_next = term_reg ? ST_WR : ST_TMUL;
            ST_WR:    state_next = (lvl_end && t_reg == ord) ? ST_ARD : ST_RD0;
            ST_ARD:   state_next = ST_AMX;
            ST_AMX:   state_next = ST_AAX;
            ST_AAX:   state_next = ST_AAY;
            ST_AAY:   state_next = acc_end ? ST_RND : ST_ARD;
            ST_RND:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        w_we      = 1'b0;
        w_wdata   = '0;
        w_raddr   = idx_reg + KIDX_W'(1);
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        case (state_reg)
            ST_VMUL: begin
                mul_a = MA_W'(s_reg);
                mul_b = $signed(MB_W'(m));
            end
            ST_INIT: begin
                w_we    = 1'b1;
                w_wdata = init_hit ? W_ONE : '0;
            end
            ST_RD0:  w_raddr = idx_reg;
            ST_TMUL: begin
                mul_a = diff;
                mul_b = $signed({1'b0, term_reg ? wb_reg : wa_reg});
            end
            ST_TDIV: div_start = !skip;
            ST_WR: begin
                w_we    = 1'b1;
                w_wdata = (sum_reg > SUM_W'(W_ONE)) ? W_ONE : sum_reg[W_W-1:0];
            end
            ST_ARD, ST_AAY, ST_RND: w_raddr = idx_reg;
            ST_AMX: begin
                w_raddr = idx_reg;
                mul_a   = MA_W'(tx_rd_reg);
                mul_b   = $signed({1'b0, w_rd_reg});
            end
            ST_AAX: begin
                w_raddr = idx_reg;
                mul_a   = MA_W'(ty_rd_reg);
                mul_b   = $signed({1'b0, w_rd_reg});
            end
            default: ;
        endcase
    end

    // State and reset-cleared registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            last_x_reg <= '0;
            last_y_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RND) begin
                last_x_reg <= round_sat(acc_x_reg);
                last_y_reg <= round_sat(acc_y_reg);
            end
        end
    end

    // Control point tables, written by requests and read by the sequencer
    always_ff @(posedge aclk) begin
        if (req.wr && 32'(req.wr_index) < MAX_POINTS) begin
            tx_mem[req.wr_index[PT_AW-1:0]] <= req.wr_x;
            ty_mem[req.wr_index[PT_AW-1:0]] <= req.wr_y;
        end
        tx_rd_reg <= tx_mem[idx_reg[PT_AW-1:0]];
        ty_rd_reg <= ty_mem[idx_reg[PT_AW-1:0]];
    end

    // Blend weight memory
    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem[idx_reg] <= w_wdata;
        end
        w_rd_reg <= w_mem[w_raddr];
    end

    // Shared multiplier, product registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    s_reg    <= req.sample;
                    ok_reg   <= ok;
                    idx_reg  <= '0;
                    t_reg    <= 4'd2;
                    term_reg <= 1'b0;
                end
            end
            ST_VSET: vv_reg <= prod_reg[VV_W-1:0];
            ST_INIT: begin
                idx_reg   <= init_end ? '0 : idx_reg + KIDX_W'(1);
                acc_x_reg <= '0;
                acc_y_reg <= '0;
            end
            ST_RD1: wa_reg <= w_rd_reg;
            ST_RD2: begin
                wb_reg  <= w_rd_reg;
                sum_reg <= '0;
            end
            ST_TMUL: dsel_reg <= d;
            ST_TDIV: if (skip) term_reg <= ~term_reg;
            ST_TWAIT: begin
                if (div_done) begin
                    sum_reg  <= sum_reg + SUM_W'(div_q);
                    term_reg <= ~term_reg;
                end
            end
            ST_WR: begin
                term_reg <= 1'b0;
                if (lvl_end) begin
                    idx_reg <= '0;
                    t_reg   <= t_reg + 4'd1;
                end else begin
                    idx_reg <= idx_reg + KIDX_W'(1);
                end
            end
            ST_AAX: acc_x_reg <= acc_x_reg + ACC_W'(prod_reg);
            ST_AAY: begin
                acc_y_reg <= acc_y_reg + ACC_W'(prod_reg);
                idx_reg   <= idx_reg + KIDX_W'(1);
            end
            default: ;
        endcase
    end

    // Shared divider: round_half_up(num / (d * 2^17)) taken as
    // floor(floor((num + d * 2^16) / 2^17) / d).
    bspe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rnd_num[38:17]),
        .divisor  (dsel_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rsp.idle     = state_reg == ST_IDLE;
    assign rsp.done     = (state_reg == ST_OUT) && out_free;
    assign rsp.x        = last_x_reg;
    assign rsp.y        = last_y_reg;
    assign rsp.in_range = ok_reg;

endmodule

>>> src/bspline_curve_point_eval_unit.sv
// ----------------------------------------------------------------------------
// B-spline curve point evaluator, top level
// Stream ports, configuration registers and the result register around the
// evaluation core.
//
//   Channel   Direction  Content
//   s_        in         point write (tuser 0) or evaluate request (tuser 1)
//   m_        out        curve point, one per evaluate request
//   cfg_      in         register write: spline order, last point index
//
// A point write leaves the block ready.
// An evaluate request is dominated by the waits on the shared divider
// during the weight updates.
// An out-of-range request skips the evaluation and answers with the last point.
// Reset is synchronous and clears the sequencer, result valid and last point.
// A result waits in the output register; a new evaluate may finish only
// after it has been taken.
// ----------------------------------------------------------------------------
module bspline_curve_point_eval_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // point_index, point_x, point_y, sample from bit 0 up, two pad bits
    input  logic [55:0]                   s_tdata,
    // cmd
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // out_x, out_y from bit 0 up
    output logic [31:0]                   m_tdata,
    // in_range
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wr_en,
    input  logic [bspe_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [3:0]                    cfg_wdata
);
    import bspe_pkg::*;

    logic [3:0]  order_reg;
    logic [3:0]  last_idx_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        s_fire;
    logic        out_free;
    bspe_req_t   req;
    bspe_rsp_t   rsp;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg    <= 4'd3;
            last_idx_reg <= 4'd3;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SPLINE_ORDER: order_reg    <= cfg_wdata;
                REG_LAST_POINT:   last_idx_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input request unpacking
    assign s_tready = rsp.idle;
    assign s_fire   = s_tvalid && s_tready;

    assign req.wr       = s_fire && !s_tuser;
    assign req.wr_index = s_tdata[3:0];
    assign req.wr_x     = s_tdata[19:4];
    assign req.wr_y     = s_tdata[35:20];
    assign req.start    = s_fire && s_tuser;
    assign req.sample   = s_tdata[53:36];
    assign req.order    = order_reg;
    assign req.last_idx = last_idx_reg;

    bspe_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .out_free (out_free),
        .rsp      (rsp)
    );

    // Output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rsp.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp.done) begin
            m_tdata_reg <= {rsp.y, rsp.x};
            m_tuser_reg <= rsp.in_range;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> src/bspe_checker.sv
// ----------------------------------------------------------------------------
// B-spline curve point evaluator: port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module bspe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [55:0]                   s_tdata,
    input logic                          s_tuser,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [31:0]                   m_tdata,
    input logic                          m_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An evaluate request makes the block busy.
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("still ready after an evaluate request");

    // A new result appears only at the end of a busy period.
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an evaluation");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind bspline_curve_point_eval_unit bspe_checker u_bspe_checker (.*);

>>> bench/bspline_curve_point_eval_unit_test.sv
// ----------------------------------------------------------------------------
// B-spline curve point evaluator testbench
// Fills the control point table, then sends evaluate requests under several
// order and point-count settings, degenerate ones included. Each curve point
// is checked against a fixed-point Cox-de Boor predictor held in the bench.
// Both stream sides idle at random, and the result side holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module bspline_curve_point_eval_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bspe_pkg::*;

    localparam int MAX_CYCLES_NS = 200_000_000;

    typedef struct {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic               in_range;
    } curve_point_t;

    typedef struct {
        logic               cmd;
        logic [3:0]         idx;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [17:0] smp;
        logic               typed;
        curve_point_t       want;
    } stim_row_t;

    typedef struct {
        int ord;
        int last;
        int items;
    } setting_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [3:0]  cfg_wdata = '0;

    bspline_curve_point_eval_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Bench copy of the block state.
    logic signed [15:0] pts_x [MAX_POINTS];
    logic signed [15:0] pts_y [MAX_POINTS];
    logic signed [15:0] held_x = '0;
    logic signed [15:0] held_y = '0;
    int                 cur_order = 3;
    int                 cur_last = 3;

    curve_point_t pending_points[$];
    int  n_errors = 0;
    int  n_points_seen = 0;
    int  n_in_range = 0;
    int  n_requests = 0;
    bit  hold_off_req = 1'b0;

    // Short gaps mostly, long ones now and then.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 120);
    endfunction

    function automatic longint div_up(longint num, longint den);
        if (num <= 0) return 0;
        return (num + den / 2) / den;
    endfunction

    function automatic logic signed [15:0] round_to_coord(longint acc);
        longint r;
        r = (acc + 32768) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    // Fixed-point Cox-de Boor evaluation of the curve at one sample.
    function automatic curve_point_t predict_curve_point(logic signed [17:0] smp);
        longint knots [KNOT_LEN];
        longint wts [KNOT_LEN];
        longint span_cnt, vv, ax, ay, d1, d2, acc, lo, hi;
        int n, k;
        bit ok;
        curve_point_t res;
        n = cur_last;
        k = cur_order;
        ok = smp > 0 && k >= 1 && k <= MAX_ORDER && n + 2 > k && n < MAX_POINTS;
        if (ok) begin
            span_cnt = n - k + 2;
            vv = longint'(smp) * span_cnt;
            for (int i = 0; i <= n + k; i++) begin
                if (i < k) knots[i] = 0;
                else if (i <= n) knots[i] = i - k + 1;
                else knots[i] = span_cnt;
            end
            for (int j = 0; j < n + k; j++) begin
                lo = knots[j] <<< FRAC_V;
                hi = knots[j+1] <<< FRAC_V;
                wts[j] = (lo <= vv && vv < hi) ? 65536 : 0;
            end
            for (int t = 2; t <= k; t++) begin
                for (int j = 0; j + t <= n + k; j++) begin
                    d1 = knots[j+t-1] - knots[j];
                    d2 = knots[j+t] - knots[j+1];
                    acc = 0;
                    if (d1 != 0)
                        acc += div_up((vv - (knots[j] <<< FRAC_V)) * wts[j], d1 <<< FRAC_V);
                    if (d2 != 0)
                        acc += div_up(((knots[j+t] <<< FRAC_V) - vv) * wts[j+1],
                                      d2 <<< FRAC_V);
                    if (acc > 65536) acc = 65536;
                    wts[j] = acc;
                end
            end
            ax = 0;
            ay = 0;
            for (int i = 0; i <= n; i++) begin
                ax += longint'(pts_x[i]) * wts[i];
                ay += longint'(pts_y[i]) * wts[i];
            end
            held_x = round_to_coord(ax);
            held_y = round_to_coord(ay);
        end
        res.out_x = held_x;
        res.out_y = held_y;
        res.in_range = ok;
        return res;
    endfunction

    // Offer one request and wait for its handshake; valid stays high when
    // no gap follows.
    task automatic send_request(stim_row_t row);
        int gap;
        curve_point_t p;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= row.cmd;
        s_tdata <= {2'b00, row.smp, row.py, row.px, row.idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_requests++;
        if (row.cmd == 1'b0) begin
            pts_x[row.idx] = row.px;
            pts_y[row.idx] = row.py;
        end else begin
            p = predict_curve_point(row.smp);
            if (row.typed) p = row.want;
            pending_points.push_back(p);
        end
    endtask

    // Registers change only once the block has drained.
    task automatic program_block(int ord, int last);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_SPLINE_ORDER;
        cfg_wdata <= 4'(ord);
        @(posedge aclk);
        cfg_addr <= REG_LAST_POINT;
        cfg_wdata <= 4'(last);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_order = ord;
        cur_last = last;
    endtask

    function automatic stim_row_t point_write(int idx, int px, int py);
        stim_row_t r;
        r = '{cmd: 1'b0, idx: 4'(idx), px: 16'(px), py: 16'(py), smp: '0,
              typed: 1'b0, want: '{0, 0, 0}};
        return r;
    endfunction

    function automatic stim_row_t eval_req(int smp);
        stim_row_t r;
        r = '{cmd: 1'b1, idx: 4'($urandom), px: 16'($urandom), py: 16'($urandom),
              smp: 18'(smp), typed: 1'b0, want: '{0, 0, 0}};
        return r;
    endfunction

    // Result side: random stalls, one long hold-off on request.
    always @(posedge aclk) begin : result_check
        int hold_cnt;
        curve_point_t exp_pt;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_points.size() == 0) begin
                    $error("curve point with no request pending");
                    n_errors++;
                end else begin
                    exp_pt = pending_points.pop_front();
                    n_points_seen++;
                    if (m_tuser) n_in_range++;
                    if (m_tdata[15:0] !== exp_pt.out_x) begin
                        $error("out_x expected %0d got %0d", exp_pt.out_x,
                               $signed(m_tdata[15:0]));
                        n_errors++;
                    end
                    if (m_tdata[31:16] !== exp_pt.out_y) begin
                        $error("out_y expected %0d got %0d", exp_pt.out_y,
                               $signed(m_tdata[31:16]));
                        n_errors++;
                    end
                    if (m_tuser !== exp_pt.in_range) begin
                        $error("in_range expected %0d got %0d", exp_pt.in_range, m_tuser);
                        n_errors++;
                    end
                end
            end
            if (hold_off_req && hold_cnt == 0) begin
                hold_cnt = 600;
                hold_off_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
            end
        end else begin
            hold_cnt = 0;
        end
    end

    initial begin
        #(MAX_CYCLES_NS);
        $display("bspline_curve_point_eval_unit_test NOT OK");
        $finish;
    end

    // Directed table, then random phases over a range of settings.
    initial begin : stimulus
        stim_row_t rows[$];
        stim_row_t r;
        setting_t plan[$];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Out of range right after reset repeats the cleared last point.
        r = eval_req(0);
        r.typed = 1'b1;
        rows.push_back(r);
        r = eval_req(-131072);
        r.typed = 1'b1;
        rows.push_back(r);
        for (int i = 0; i < MAX_POINTS; i++)
            rows.push_back(point_write(i, (i % 2) ? 32767 : -32768,
                                       (i % 2) ? -32768 : 32767));
        rows.push_back(eval_req(1));
        rows.push_back(eval_req(65536));
        rows.push_back(eval_req(131071));
        // Out of range after a real point repeats that point.
        rows.push_back(eval_req(-1));
        rows.push_back(point_write(2, 0, 0));
        rows.push_back(eval_req(98304));
        foreach (rows[i]) send_request(rows[i]);

        plan = '{'{3, 3, 400}, '{2, 5, 300}, '{0, 3, 60}, '{4, 6, 250}, '{1, 0, 150},
                 '{1, 4, 150}, '{5, 7, 100}, '{2, 1, 150}, '{8, 9, 12}, '{8, 15, 8},
                 '{9, 12, 60}, '{15, 15, 40}, '{6, 4, 60}, '{3, 3, 20}};
        foreach (plan[p]) begin
            program_block(plan[p].ord, plan[p].last);
            // Quick degenerate answers let the block back up during a hold-off.
            if (plan[p].ord == 0) hold_off_req = 1'b1;
            for (int i = 0; i < plan[p].items; i++) begin
                if ($urandom_range(0, 2) == 0)
                    r = point_write($urandom_range(0, 15), $urandom, $urandom);
                else if ($urandom_range(0, 9) < 8)
                    r = eval_req($urandom_range(1, 131071));
                else
                    r = eval_req(int'($signed(18'($urandom))));
                send_request(r);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_points.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d requests over %0d settings; checked %0d curve points, %0d in range.",
                 n_requests, plan.size() + 1, n_points_seen, n_in_range);
        if (n_errors == 0)
            $display("bspline_curve_point_eval_unit_test OK");
        else
            $display("bspline_curve_point_eval_unit_test NOT OK");
        $finish;
    end
endmodule
